// ----- design/fft_pkg.sv -----
`timescale 1ns / 1ps
// fft_pkg: shared constants, types and twiddle rom for the in-place radix-2 fft
// no dependencies

package fft_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxLog    = $clog2(MaxPoints);
  localparam int AddrW     = MaxLog;
  localparam int DataW     = 23;
  localparam int TwQ       = 16;           // quarter-wave span of the table at 64 points

  localparam logic [0:0] RegSizeLog2   = 1'b0;
  localparam logic [0:0] RegInverse    = 1'b1;

  typedef logic signed [DataW-1:0] sample_t;

  // quarter-wave sine rom, 18-bit signed q3.15 with 1.0 held as 32768
  function automatic logic signed [17:0] sin_rom(input logic [4:0] i);
    logic signed [17:0] r;
    case (i)
      5'd0:  r = 18'sd0;
      5'd1:  r = 18'sd3212;
      5'd2:  r = 18'sd6393;
      5'd3:  r = 18'sd9512;
      5'd4:  r = 18'sd12540;
      5'd5:  r = 18'sd15447;
      5'd6:  r = 18'sd18205;
      5'd7:  r = 18'sd20788;
      5'd8:  r = 18'sd23170;
      5'd9:  r = 18'sd25330;
      5'd10: r = 18'sd27246;
      5'd11: r = 18'sd28899;
      5'd12: r = 18'sd30274;
      5'd13: r = 18'sd31357;
      5'd14: r = 18'sd32138;
      5'd15: r = 18'sd32610;
      5'd16: r = 18'sd32768;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/radix2_fft_inplace_top.sv -----
`timescale 1ns / 1ps
// radix2_fft_inplace_top: in-place radix-2 fft with one butterfly unit
// depends on fft_pkg
// after the last sample beat, N/2*log2(N) butterflies each run read top, read bottom,
// multiply, write top, write bottom; each bin is then read into rdata and registered at
// the outputs, one bin per cycle unless out_stall holds them; load takes one beat a
// cycle unless stalled; throughput set by single write port and unpipelined butterfly
// reset: synchronous, clears control state; size 64, forward; memory is not cleared
module radix2_fft_inplace_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] sample_real,
  input  logic signed [15:0] sample_imag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [22:0] bin_real,
  output logic signed [22:0] bin_imag,
  output logic        bin_last
);

  localparam int AW = fft_pkg::AddrW;
  localparam int DW = fft_pkg::DataW;
  localparam int LW = $clog2(fft_pkg::MaxLog + 1);

  typedef enum logic [2:0] {S_LOAD, S_RDA, S_RDB, S_MUL, S_WRA, S_WRB, S_OUT} state_t;

  state_t            state;
  logic [2:0]        size_log2;
  logic              inverse_mode;
  logic [AW:0]       load_count;
  logic [LW-1:0]     stage;
  logic [AW-1:0]     bfly;
  logic [AW:0]       out_count;
  logic              out_rd_pend;

  // sample memory, real and imaginary packed
  logic [2*DW-1:0]   mem [fft_pkg::MaxPoints];
  logic [2*DW-1:0]   rdata;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [2*DW-1:0]   wdata;

  // effective size
  logic [LW-1:0]     lg;
  logic [AW:0]       npts;
  assign lg   = (size_log2 > 3'(fft_pkg::MaxLog)) ? LW'(fft_pkg::MaxLog) : LW'(size_log2);
  assign npts = (AW+1)'(1) << lg;

  // handshake terms
  logic in_acc, frame_done, out_take, out_issue, bfly_end, stage_end;
  assign in_stall   = (state != S_LOAD) || cfg_we;
  assign in_acc     = in_valid && !in_stall;
  assign frame_done = (load_count + (AW+1)'(1)) == npts;
  assign out_take   = (state == S_OUT) && out_rd_pend && (!out_valid || !out_stall);
  assign out_issue  = (state == S_OUT) && (out_count < npts) && (!out_rd_pend || out_take);

  // bit-reversed load address
  logic [AW-1:0] rev_full, rev_addr;
  always_comb begin
    for (int b = 0; b < AW; b++) rev_full[AW-1-b] = load_count[b];
  end
  assign rev_addr = rev_full >> (LW'(AW) - lg);

  // butterfly addresses: insert a zero bit at position stage
  logic [AW-1:0] half, mask_lo, top_addr, bot_addr, kidx;
  assign half     = AW'(1) << stage;
  assign mask_lo  = half - AW'(1);
  assign top_addr = ((bfly & ~mask_lo) << 1) | (bfly & mask_lo);
  assign bot_addr = top_addr | half;
  assign kidx     = bfly & mask_lo;
  assign bfly_end  = ((AW+1)'(bfly) + (AW+1)'(1)) == (npts >> 1);
  assign stage_end = (stage + LW'(1)) == lg;

  // twiddle index scaled to the 64-point table
  logic [AW-1:0] tw_a;
  logic signed [17:0] tw_c, tw_s, wr, wi;
  assign tw_a = kidx << (LW'(AW - 1) - stage);
  always_comb begin
    if (tw_a <= AW'(fft_pkg::TwQ)) begin
      tw_s = fft_pkg::sin_rom(5'(tw_a));
      tw_c = fft_pkg::sin_rom(5'(AW'(fft_pkg::TwQ) - tw_a));
    end else begin
      tw_s = fft_pkg::sin_rom(5'(AW'(2 * fft_pkg::TwQ) - tw_a));
      tw_c = -fft_pkg::sin_rom(5'(tw_a - AW'(fft_pkg::TwQ)));
    end
  end

  // butterfly datapath registers
  fft_pkg::sample_t ar, ai, rd_re, rd_im;
  logic signed [40:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [41:0] sum_r, sum_i;
  logic signed [DW-1:0] tr, ti;
  assign rd_re = rdata[2*DW-1:DW];
  assign rd_im = rdata[DW-1:0];
  assign sum_r = 42'(p_rr) - 42'(p_ii) + 42'sd16384;
  assign sum_i = 42'(p_ri) + 42'(p_ir) + 42'sd16384;
  assign tr = sum_r[DW+14:15];
  assign ti = sum_i[DW+14:15];

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = rev_addr;
    wdata = {DW'(sample_real), DW'(sample_imag)};
    raddr = top_addr;
    unique case (state)
      S_LOAD: we = in_acc;
      S_RDA:  re = 1'b1;
      S_RDB: begin
        re = 1'b1; raddr = bot_addr;
      end
      S_MUL:  ;
      S_WRA: begin
        we = 1'b1; waddr = top_addr; wdata = {ar + tr, ai + ti};
      end
      S_WRB: begin
        we = 1'b1; waddr = bot_addr; wdata = {ar - tr, ai - ti};
      end
      S_OUT: begin
        re = out_issue; raddr = out_count[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // operand capture, products and output bin register
  always_ff @(posedge clk) begin
    if (state == S_RDB) begin
      ar <= rd_re;
      ai <= rd_im;
      wr <= tw_c;
      wi <= inverse_mode ? -tw_s : tw_s;
    end
    if (state == S_MUL) begin
      p_rr <= wr * rd_re;
      p_ii <= wi * rd_im;
      p_ri <= wr * rd_im;
      p_ir <= wi * rd_re;
    end
    if (out_take) begin
      bin_real <= rd_re;
      bin_imag <= rd_im;
      bin_last <= (out_count == npts);
    end
  end

  // sequencer: load, butterfly stages, then bins in natural order
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      size_log2    <= 3'd6;
      inverse_mode <= 1'b0;
      load_count   <= '0;
      stage        <= '0;
      bfly         <= '0;
      out_count    <= '0;
      out_rd_pend  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fft_pkg::RegSizeLog2: size_log2    <= cfg_data;
          fft_pkg::RegInverse:  inverse_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      // any register write abandons a partly loaded frame
      if (cfg_we) load_count <= '0;
      else if (in_acc) load_count <= frame_done ? '0 : load_count + (AW+1)'(1);
      unique case (state)
        S_LOAD: begin
          if (in_acc && frame_done) begin
            stage     <= '0;
            bfly      <= '0;
            out_count <= '0;
            state     <= (lg == '0) ? S_OUT : S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: state <= S_MUL;
        S_MUL: state <= S_WRA;
        S_WRA: state <= S_WRB;
        S_WRB: begin
          if (bfly_end) begin
            bfly <= '0;
            if (stage_end) begin
              state <= S_OUT;
            end else begin
              stage <= stage + LW'(1);
              state <= S_RDA;
            end
          end else begin
            bfly  <= bfly + AW'(1);
            state <= S_RDA;
          end
        end
        S_OUT: begin
          if (out_issue) out_count <= out_count + (AW+1)'(1);
          if (out_issue) out_rd_pend <= 1'b1;
          else if (out_take) out_rd_pend <= 1'b0;
          // last bin in the output register frees the memory for loading
          if (out_take && out_count == npts) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for radix2_fft_inplace_top, with a bit-true fft predictor
// depends on fft_pkg and radix2_fft_inplace_top

module tb_top;

  typedef struct {
    logic signed [22:0] re;
    logic signed [22:0] im;
    logic               last;
  } fft_bin_t;

  // bit-true fft predictor and queue of expected bins
  class fft_scoreboard;
    logic [2:0]         size_reg;
    logic               inv_reg;
    logic signed [22:0] mem_re[64];
    logic signed [22:0] mem_im[64];
    int                 fill;
    fft_bin_t           pending_bins[$];
    int                 errors;
    int                 sin_q[17];

    function new();
      sin_q = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
      size_reg = 3'd6;
      inv_reg  = 1'b0;
      fill     = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [2:0] val);
      if (idx == fft_pkg::RegSizeLog2) size_reg = val;
      else inv_reg = val[0];
      fill = 0;
    endfunction

    // half-up rounding of a q30 product sum back to q15
    function longint round15(longint p);
      return (p + 16384) >>> 15;
    endfunction

    function void run_fft(int lg);
      int n, j, span, ang;
      longint wr, wi, br, bi, tr, ti;
      logic signed [22:0] tmp;
      n = 1 << lg;
      // bit-reversed reorder
      for (int i = 0; i < n; i++) begin
        j = 0;
        for (int b = 0; b < lg; b++) j |= ((i >> b) & 1) << (lg - 1 - b);
        if (j > i) begin
          tmp = mem_re[i]; mem_re[i] = mem_re[j]; mem_re[j] = tmp;
          tmp = mem_im[i]; mem_im[i] = mem_im[j]; mem_im[j] = tmp;
        end
      end
      // butterfly stages
      for (span = 1; span < n; span <<= 1) begin
        for (int k = 0; k < span; k++) begin
          ang = k * (64 / (2 * span));
          if (ang <= 16) begin
            wi = sin_q[ang]; wr = sin_q[16 - ang];
          end else begin
            wi = sin_q[32 - ang]; wr = -sin_q[ang - 16];
          end
          if (inv_reg) wi = -wi;
          for (int base = k; base < n; base += 2 * span) begin
            br = mem_re[base + span];
            bi = mem_im[base + span];
            tr = round15(wr * br - wi * bi);
            ti = round15(wr * bi + wi * br);
            mem_re[base + span] = 23'(longint'(mem_re[base]) - tr);
            mem_im[base + span] = 23'(longint'(mem_im[base]) - ti);
            mem_re[base] = 23'(longint'(mem_re[base]) + tr);
            mem_im[base] = 23'(longint'(mem_im[base]) + ti);
          end
        end
      end
    endfunction

    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
      int lg, n;
      fft_bin_t b;
      lg = (size_reg > 6) ? 6 : size_reg;
      n  = 1 << lg;
      if (fill >= n) fill = 0;
      mem_re[fill] = re;
      mem_im[fill] = im;
      fill++;
      if (fill < n) return;
      fill = 0;
      run_fft(lg);
      for (int k = 0; k < n; k++) begin
        b.re = mem_re[k]; b.im = mem_im[k]; b.last = (k == n - 1);
        pending_bins.insert(pending_bins.size(), b);
      end
    endfunction

    function void check_bin(logic signed [22:0] re, logic signed [22:0] im, logic last);
      fft_bin_t e;
      if (pending_bins.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected bin re=%0d im=%0d last=%0b", re, im, last);
        return;
      end
      e = pending_bins.pop_front();
      if (e.re !== re || e.im !== im || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("bin mismatch: exp re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                   e.re, e.im, e.last, re, im, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = fft_pkg::RegSizeLog2;
  logic [2:0] cfg_data = 3'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample_real = '0;
  logic signed [15:0] sample_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [22:0] bin_real;
  logic signed [22:0] bin_imag;
  logic bin_last;

  fft_scoreboard fft_sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 0;
  int  sent_count = 0;

  radix2_fft_inplace_top dut (.*);

  always #5 clk = ~clk;

  // monitor both handshakes
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) fft_sb.note_sample(sample_real, sample_imag);
    if (!rst && out_valid && !out_stall) fft_sb.check_bin(bin_real, bin_imag, bin_last);
  end

  // receiver stall, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        for (int c = 0; c < 3000; c++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_real <= re;
    sample_imag <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fft_sb.pending_bins.size() != 0) @(posedge clk);
    // a partly loaded frame leaves nothing pending, so allow a short settle
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [2:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    fft_sb.set_reg(idx, val);
  endtask

  function automatic logic signed [15:0] rand_sample(int kind);
    case (kind)
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int lg);
    int kind;
    kind = $urandom_range(3);
    for (int i = 0; i < (1 << ((lg > 6) ? 6 : lg)); i++)
      send_sample(rand_sample(kind), rand_sample(kind));
  endtask

  // overall limit
  initial begin
    #20ms;
    $display("radix2_fft_inplace_top verification failed");
    $finish;
  end

  initial begin
    int lg;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-point frames pass through with extremes
    write_reg(fft_pkg::RegSizeLog2, 3'd0);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, -16'sd1);
    send_sample(-16'sd1, 16'sh0000);
    // two-point forward and inverse
    write_reg(fft_pkg::RegSizeLog2, 3'd1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    write_reg(fft_pkg::RegInverse, 3'd1);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    // four-point inverse
    write_reg(fft_pkg::RegSizeLog2, 3'd2);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh0000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh8000);
    // partly loaded frame abandoned by a register write
    write_reg(fft_pkg::RegSizeLog2, 3'd3);
    send_sample(16'sd100, 16'sd200);
    send_sample(16'sd300, 16'sd400);
    send_sample(16'sd500, 16'sd600);
    write_reg(fft_pkg::RegInverse, 3'd0);
    for (int i = 0; i < 8; i++) send_sample(16'sh7fff, 16'sh8000);

    // random frames over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 34 : 0;
      recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 34 : 0;
      if (phase == 0) begin
        write_reg(fft_pkg::RegSizeLog2, 3'd7);
        write_reg(fft_pkg::RegInverse, 3'd1);
        hold_req = 1;
        send_frame(7);
        send_frame(7);
      end
      while (sent_count < 160 + 25 * (phase + 1)) begin
        lg = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
        write_reg(fft_pkg::RegSizeLog2, 3'(lg));
        write_reg(fft_pkg::RegInverse, 3'($urandom_range(1)));
        repeat ($urandom_range(3, 1)) send_frame(lg);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (fft_sb.errors == 0 && fft_sb.pending_bins.size() == 0) begin
      $display("radix2_fft_inplace_top verification clean");
    end else begin
      $display("radix2_fft_inplace_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/fft_pkg.sv
design/radix2_fft_inplace_top.sv
verif/tb_top.sv
